// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RGPT_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define RGPT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`define RGPT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RGPT_ASSERT(lbl, clk, rst_n, cond)
`define RGPT_IMPLY(lbl, clk, rst_n, ante, cons)
`define RGPT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/rgpt_pkg.sv -----
// Types and constants of the range gated pan tracker.
`default_nettype none
package rgpt_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int PAN_W  = 12;
  localparam int DIST_W = 16;
  localparam int STR_W  = 16;
  localparam int GATE_W = 8;
  localparam int STEP_W = 8;

  // running totals: one field width plus headroom for the point cap
  localparam int PT_W  = PAN_W + $clog2(MAX_POINTS);
  localparam int DT_W  = DIST_W + $clog2(MAX_POINTS);
  localparam int IDX_W = $clog2(DT_W);
  localparam int BAR_W = DIST_W + 2;
  localparam int PCALC_W = PAN_W + 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_HALF_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_STEP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_LOW         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_HIGH        = 3'd4;

  localparam logic [GATE_W-1:0] RST_GATE_HALF_WIDTH = 8'd10;
  localparam logic [STEP_W-1:0] RST_PAN_STEP        = 8'd33;
  localparam logic [STR_W-1:0]  RST_STRENGTH_MIN    = 16'd1000;
  localparam logic [PAN_W-1:0]  RST_PAN_LOW         = 12'd500;
  localparam logic [PAN_W-1:0]  RST_PAN_HIGH        = 12'd2500;
  localparam logic [PAN_W-1:0]  RST_PAN_POSITION    = 12'd1666;
  localparam logic [DIST_W-1:0] RST_TRACK_DIST      = 16'd100;

  typedef struct packed {
    logic [PAN_W-1:0]  sample_pan;
    logic [DIST_W-1:0] sample_distance;
    logic [STR_W-1:0]  sample_strength;
    logic              frame_end;
  } in_t;

  typedef struct packed {
    logic [PAN_W-1:0]  next_pan;
    logic [DIST_W-1:0] new_tracking_distance;
    logic [PAN_W-1:0]  mean_pan;
    logic              target_found;
  } out_t;

  typedef struct packed {
    logic [GATE_W-1:0] gate_half_width;
    logic [STEP_W-1:0] pan_step;
    logic [STR_W-1:0]  strength_min;
    logic [PAN_W-1:0]  pan_low;
    logic [PAN_W-1:0]  pan_high;
  } cfg_t;

  typedef struct packed {
    logic keep;
    logic gated;
  } gate_t;

  // controls for the serial accumulate / divide unit
  typedef struct packed {
    logic             load;
    logic             acc;
    logic             div;
    logic             clr;
    logic [IDX_W-1:0] step;
  } sctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/range_gated_pan_tracker.sv -----
// Range gated pan tracker: collects lidar samples per frame, steers pan on frame end.
//
// Timing: a sample that is dropped or falls outside the distance gate leaves
// the unit idle unless it ends the frame. A gated sample is added into the pan
// and distance totals, which are shift registers, one bit per cycle in ST_ACC.
// On the frame's last sample, if anything was gated, the same registers run
// as a restoring divider by the gated count, one quotient bit per cycle in
// ST_DIV, then ST_DONE loads the result register and waits there while the
// previous result still sits stalled in the output register. in_stall is high
// whenever the unit is busy; a pending result in the output register does not
// block new samples, only the next frame decision. Config writes are taken
// every cycle (cfg_ready is tied high) and must only happen while idle.
`default_nettype none
`include "assert_macros.svh"
module range_gated_pan_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rgpt_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rgpt_pkg::out_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  rgpt_pkg::cfg_t                  cfg_r, cfg_nxt;
  logic [rgpt_pkg::PAN_W-1:0]      pan_pos_r, pan_pos_nxt;
  logic [rgpt_pkg::DIST_W-1:0]     track_r, track_nxt;
  logic [rgpt_pkg::CNT_W-1:0]      gated_cnt_r, gated_cnt_nxt;
  logic [rgpt_pkg::CNT_W-1:0]      points_r, points_nxt;
  logic                            last_r, last_nxt;
  logic [rgpt_pkg::IDX_W-1:0]      step_r, step_nxt;
  logic                            out_valid_r, out_valid_nxt;
  rgpt_pkg::out_t                  out_data_r, out_data_nxt;

  logic                            in_accept;
  logic                            out_load;
  logic                            step_last;
  logic                            found;
  rgpt_pkg::gate_t                 gate;
  rgpt_pkg::sctl_t                 sctl;
  logic [rgpt_pkg::PAN_W-1:0]      quot_pan;
  logic [rgpt_pkg::DIST_W-1:0]     quot_dist;
  logic [rgpt_pkg::PAN_W-1:0]      mean_p;
  logic signed [rgpt_pkg::PCALC_W-1:0] pan_calc;
  logic signed [rgpt_pkg::PCALC_W-1:0] pan_sat;

  rgpt_gate u_gate (
    .sample     (in_data),
    .cfg        (cfg_r),
    .track_dist (track_r),
    .points     (points_r),
    .result     (gate)
  );

  rgpt_sdiv u_sdiv (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (sctl),
    .sample_pan  (in_data.sample_pan),
    .sample_dist (in_data.sample_distance),
    .divisor     (gated_cnt_r),
    .quot_pan    (quot_pan),
    .quot_dist   (quot_dist)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign step_last = (step_r == rgpt_pkg::IDX_W'(rgpt_pkg::DT_W - 1));
  assign found     = (gated_cnt_r != '0);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign mean_p    = found ? quot_pan : '0;

  // frame decision: step up only when mean pan is above, step down when no target
  always_comb begin
    pan_calc = $signed({2'b00, pan_pos_r});
    if (found) begin
      if (mean_p > pan_pos_r) begin
        pan_calc = pan_calc + $signed({{(rgpt_pkg::PCALC_W - rgpt_pkg::STEP_W){1'b0}},
                                       cfg_r.pan_step});
      end
    end else begin
      pan_calc = pan_calc - $signed({{(rgpt_pkg::PCALC_W - rgpt_pkg::STEP_W){1'b0}},
                                     cfg_r.pan_step});
    end
    // upper limit first, lower limit wins when they cross
    pan_sat = pan_calc;
    if (pan_sat >= $signed({2'b00, cfg_r.pan_high})) begin
      pan_sat = $signed({2'b00, cfg_r.pan_high});
    end
    if (pan_sat <= $signed({2'b00, cfg_r.pan_low})) begin
      pan_sat = $signed({2'b00, cfg_r.pan_low});
    end
  end

  // config register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rgpt_pkg::CFG_GATE_HALF_WIDTH: cfg_nxt.gate_half_width = cfg_data[rgpt_pkg::GATE_W-1:0];
        rgpt_pkg::CFG_PAN_STEP:        cfg_nxt.pan_step        = cfg_data[rgpt_pkg::STEP_W-1:0];
        rgpt_pkg::CFG_STRENGTH_MIN:    cfg_nxt.strength_min    = cfg_data[rgpt_pkg::STR_W-1:0];
        rgpt_pkg::CFG_PAN_LOW:         cfg_nxt.pan_low         = cfg_data[rgpt_pkg::PAN_W-1:0];
        rgpt_pkg::CFG_PAN_HIGH:        cfg_nxt.pan_high        = cfg_data[rgpt_pkg::PAN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pan_pos_nxt   = pan_pos_r;
    track_nxt     = track_r;
    gated_cnt_nxt = gated_cnt_r;
    points_nxt    = points_r;
    last_nxt      = last_r;
    step_nxt      = step_r;
    out_data_nxt  = out_data_r;
    sctl          = '0;
    sctl.step     = step_r;

    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_accept) begin
          sctl.load = 1'b1;
          last_nxt  = in_data.frame_end;
          if (gate.keep) begin
            points_nxt = points_r + 1'b1;
          end
          if (gate.gated) begin
            gated_cnt_nxt = gated_cnt_r + 1'b1;
            state_nxt     = ST_ACC;
          end else if (in_data.frame_end) begin
            // nothing to add: go straight to divide, or to decision if empty
            state_nxt = found ? ST_DIV : ST_DONE;
          end
        end
      end
      ST_ACC: begin
        sctl.acc = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_last) begin
          step_nxt  = '0;
          state_nxt = last_r ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        sctl.div = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_last) begin
          step_nxt  = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          pan_pos_nxt = pan_sat[rgpt_pkg::PAN_W-1:0];
          if (found) begin
            track_nxt = quot_dist;
          end
          out_data_nxt.next_pan              = pan_sat[rgpt_pkg::PAN_W-1:0];
          out_data_nxt.new_tracking_distance = found ? quot_dist : track_r;
          out_data_nxt.mean_pan              = mean_p;
          out_data_nxt.target_found          = found;
          out_valid_nxt = 1'b1;
          // frame closed: totals and counts back to zero
          sctl.clr      = 1'b1;
          gated_cnt_nxt = '0;
          points_nxt    = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_r.gate_half_width <= rgpt_pkg::RST_GATE_HALF_WIDTH;
      cfg_r.pan_step        <= rgpt_pkg::RST_PAN_STEP;
      cfg_r.strength_min    <= rgpt_pkg::RST_STRENGTH_MIN;
      cfg_r.pan_low         <= rgpt_pkg::RST_PAN_LOW;
      cfg_r.pan_high        <= rgpt_pkg::RST_PAN_HIGH;
      pan_pos_r   <= rgpt_pkg::RST_PAN_POSITION;
      track_r     <= rgpt_pkg::RST_TRACK_DIST;
      gated_cnt_r <= '0;
      points_r    <= '0;
      last_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      pan_pos_r   <= pan_pos_nxt;
      track_r     <= track_nxt;
      gated_cnt_r <= gated_cnt_nxt;
      points_r    <= points_nxt;
      last_r      <= last_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `RGPT_ASSERT(a_gated_le_points, clk, rst_n, gated_cnt_r <= points_r)
  `RGPT_ASSERT(a_points_cap, clk, rst_n, points_r <= rgpt_pkg::CNT_W'(rgpt_pkg::MAX_POINTS))
  `RGPT_IMPLY(a_div_nonzero, clk, rst_n, state_r == ST_DIV, gated_cnt_r != '0)
  `RGPT_NEXT(a_frame_cleared, clk, rst_n, out_load, points_r == '0 && gated_cnt_r == '0 && out_valid_r)

endmodule
`default_nettype wire

// ----- hw/rtl/rgpt_gate.sv -----
// Sample qualification: strength threshold, point cap and distance gate.
`default_nettype none
module rgpt_gate (
  input  rgpt_pkg::in_t                   sample,
  input  rgpt_pkg::cfg_t                  cfg,
  input  logic [rgpt_pkg::DIST_W-1:0]     track_dist,
  input  logic [rgpt_pkg::CNT_W-1:0]      points,
  output rgpt_pkg::gate_t                 result
);

  logic signed [rgpt_pkg::BAR_W-1:0] low_bar;
  logic signed [rgpt_pkg::BAR_W-1:0] upper_bar;
  logic signed [rgpt_pkg::BAR_W-1:0] dist_s;
  logic signed [rgpt_pkg::BAR_W-1:0] gate_s;
  logic signed [rgpt_pkg::BAR_W-1:0] track_s;

  assign track_s   = $signed({2'b00, track_dist});
  assign gate_s    = $signed({{(rgpt_pkg::BAR_W - rgpt_pkg::GATE_W){1'b0}},
                              cfg.gate_half_width});
  assign dist_s    = $signed({2'b00, sample.sample_distance});
  assign low_bar   = track_s - gate_s;
  assign upper_bar = track_s + gate_s;

  assign result.keep  = (sample.sample_strength >= cfg.strength_min) &&
                        (points < rgpt_pkg::CNT_W'(rgpt_pkg::MAX_POINTS));
  // strict window on both sides
  assign result.gated = result.keep && (dist_s > low_bar) && (dist_s < upper_bar);

endmodule
`default_nettype wire

// ----- hw/rtl/rgpt_sdiv.sv -----
// Bit-serial accumulator for pan/distance totals, reused as restoring divider.
`default_nettype none
module rgpt_sdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rgpt_pkg::sctl_t               ctl,
  input  logic [rgpt_pkg::PAN_W-1:0]    sample_pan,
  input  logic [rgpt_pkg::DIST_W-1:0]   sample_dist,
  input  logic [rgpt_pkg::CNT_W-1:0]    divisor,
  output logic [rgpt_pkg::PAN_W-1:0]    quot_pan,
  output logic [rgpt_pkg::DIST_W-1:0]   quot_dist
);

  logic [rgpt_pkg::PT_W-1:0]   pt_r, pt_nxt;
  logic [rgpt_pkg::DT_W-1:0]   dt_r, dt_nxt;
  logic [rgpt_pkg::PAN_W-1:0]  sp_r, sp_nxt;
  logic [rgpt_pkg::DIST_W-1:0] sd_r, sd_nxt;
  logic                        pc_r, pc_nxt;
  logic                        dc_r, dc_nxt;
  logic [rgpt_pkg::CNT_W-1:0]  prem_r, prem_nxt;
  logic [rgpt_pkg::CNT_W-1:0]  drem_r, drem_nxt;

  logic                        pan_on;
  logic                        psum, dsum;
  logic [rgpt_pkg::CNT_W-1:0]  prem_in, drem_in;
  logic [rgpt_pkg::CNT_W:0]    ptrial, dtrial, pdiff, ddiff, dvs;
  logic                        pge, dge;

  // pan total is narrower; it only moves during the first PT_W steps
  assign pan_on = ctl.step < rgpt_pkg::IDX_W'(rgpt_pkg::PT_W);

  assign psum = pt_r[0] ^ sp_r[0] ^ pc_r;
  assign dsum = dt_r[0] ^ sd_r[0] ^ dc_r;

  assign prem_in = (ctl.step == '0) ? '0 : prem_r;
  assign drem_in = (ctl.step == '0) ? '0 : drem_r;
  assign dvs     = {1'b0, divisor};
  assign ptrial  = {prem_in, pt_r[rgpt_pkg::PT_W-1]};
  assign dtrial  = {drem_in, dt_r[rgpt_pkg::DT_W-1]};
  assign pdiff   = ptrial - dvs;
  assign ddiff   = dtrial - dvs;
  assign pge     = ptrial >= dvs;
  assign dge     = dtrial >= dvs;

  always_comb begin
    pt_nxt   = pt_r;
    dt_nxt   = dt_r;
    sp_nxt   = sp_r;
    sd_nxt   = sd_r;
    pc_nxt   = pc_r;
    dc_nxt   = dc_r;
    prem_nxt = prem_r;
    drem_nxt = drem_r;
    if (ctl.load) begin
      sp_nxt = sample_pan;
      sd_nxt = sample_dist;
      pc_nxt = 1'b0;
      dc_nxt = 1'b0;
    end
    if (ctl.acc) begin
      // LSB first, rotating right
      dt_nxt = {dsum, dt_r[rgpt_pkg::DT_W-1:1]};
      dc_nxt = (dt_r[0] & sd_r[0]) | (dc_r & (dt_r[0] ^ sd_r[0]));
      sd_nxt = {1'b0, sd_r[rgpt_pkg::DIST_W-1:1]};
      if (pan_on) begin
        pt_nxt = {psum, pt_r[rgpt_pkg::PT_W-1:1]};
        pc_nxt = (pt_r[0] & sp_r[0]) | (pc_r & (pt_r[0] ^ sp_r[0]));
        sp_nxt = {1'b0, sp_r[rgpt_pkg::PAN_W-1:1]};
      end
    end
    if (ctl.div) begin
      // MSB first; quotient bits shift in at the bottom
      dt_nxt   = {dt_r[rgpt_pkg::DT_W-2:0], dge};
      drem_nxt = dge ? ddiff[rgpt_pkg::CNT_W-1:0] : dtrial[rgpt_pkg::CNT_W-1:0];
      if (pan_on) begin
        pt_nxt   = {pt_r[rgpt_pkg::PT_W-2:0], pge};
        prem_nxt = pge ? pdiff[rgpt_pkg::CNT_W-1:0] : ptrial[rgpt_pkg::CNT_W-1:0];
      end
    end
    if (ctl.clr) begin
      pt_nxt = '0;
      dt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= '0;
      dt_r <= '0;
    end else begin
      pt_r <= pt_nxt;
      dt_r <= dt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r   <= sp_nxt;
    sd_r   <= sd_nxt;
    pc_r   <= pc_nxt;
    dc_r   <= dc_nxt;
    prem_r <= prem_nxt;
    drem_r <= drem_nxt;
  end

  assign quot_pan  = pt_r[rgpt_pkg::PAN_W-1:0];
  assign quot_dist = dt_r[rgpt_pkg::DIST_W-1:0];

endmodule
`default_nettype wire

// ----- verif/range_gated_pan_tracker_test.sv -----
// Self-checking testbench for the range gated pan tracker: predicts every frame decision.
module range_gated_pan_tracker_test;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [rgpt_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  // Worst-case busy time of one transaction (gated sample plus divide) with margin.
  localparam int SETTLE_CYCLES = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  rgpt_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rgpt_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rgpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rgpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  range_gated_pan_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Samples waiting to be sent; the head is what the driver presents.
  rgpt_pkg::in_t sample_q[$];
  // Frame decisions predicted but not yet seen on the result channel.
  rgpt_pkg::out_t decision_q[$];

  int mismatches = 0;
  // Percent chance per cycle of starting an idle burst; 0 means full rate.
  int idle_pct = 0;
  bit calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  // Shadow copy of the configuration registers.
  logic [rgpt_pkg::GATE_W-1:0] gate_hw = rgpt_pkg::RST_GATE_HALF_WIDTH;
  logic [rgpt_pkg::STEP_W-1:0] step_sz = rgpt_pkg::RST_PAN_STEP;
  logic [rgpt_pkg::STR_W-1:0]  str_min = rgpt_pkg::RST_STRENGTH_MIN;
  logic [rgpt_pkg::PAN_W-1:0]  pan_lo  = rgpt_pkg::RST_PAN_LOW;
  logic [rgpt_pkg::PAN_W-1:0]  pan_hi  = rgpt_pkg::RST_PAN_HIGH;

  // Shadow copy of the tracker state.
  logic [rgpt_pkg::PAN_W-1:0]  pan_pos   = rgpt_pkg::RST_PAN_POSITION;
  logic [rgpt_pkg::DIST_W-1:0] trk_dist  = rgpt_pkg::RST_TRACK_DIST;
  int pan_sum  = 0;
  int dist_sum = 0;
  int hits     = 0;
  int kept     = 0;

  // Apply one accepted sample to the shadow state; a frame end queues the decision.
  task automatic track_sample(input rgpt_pkg::in_t s);
    int lo_bar, hi_bar, d, p, step_i, lo_i, hi_i;
    rgpt_pkg::out_t r;
    d = int'(s.sample_distance);
    if (s.sample_strength >= str_min && kept < rgpt_pkg::MAX_POINTS) begin
      // window is open on both sides and may dip below zero
      lo_bar = int'(trk_dist) - int'(gate_hw);
      hi_bar = int'(trk_dist) + int'(gate_hw);
      kept++;
      if (d > lo_bar && d < hi_bar) begin
        pan_sum += int'(s.sample_pan);
        dist_sum += d;
        hits++;
      end
    end
    if (s.frame_end) begin
      step_i = int'(step_sz);
      lo_i = int'(pan_lo);
      hi_i = int'(pan_hi);
      p = int'(pan_pos);
      r.mean_pan = '0;
      r.target_found = (hits > 0);
      if (hits > 0) begin
        trk_dist = rgpt_pkg::DIST_W'(dist_sum / hits);
        r.mean_pan = rgpt_pkg::PAN_W'(pan_sum / hits);
        // no step at all when the mean sits at or below the current pan
        if (r.mean_pan > pan_pos) p = p + step_i;
      end else begin
        p = p - step_i;
      end
      // upper limit first, so a crossed pair leaves pan_lo in charge
      if (p >= hi_i) p = hi_i;
      if (p <= lo_i) p = lo_i;
      if (p < 0) p = 0;
      pan_pos = p[rgpt_pkg::PAN_W-1:0];
      r.next_pan = pan_pos;
      r.new_tracking_distance = trk_dist;
      decision_q.push_back(r);
      pan_sum = 0;
      dist_sum = 0;
      hits = 0;
      kept = 0;
    end
  endtask

  // Driver: holds a stalled transaction steady, otherwise idles or presents the next sample.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        track_sample(in_data);
        void'(sample_q.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0 && idle_pct != 0 &&
                   $urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= sample_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted decision against the oldest prediction and
  // throws random stall bursts at the result channel.
  always @(posedge clk) begin
    rgpt_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decision_q.size() == 0) begin
          $display("%0t: decision expected none, actual %p", $time, out_data);
          mismatches++;
        end else begin
          want = decision_q.pop_front();
          if (out_data.next_pan !== want.next_pan) begin
            $display("%0t: next_pan expected %0d actual %0d",
                     $time, want.next_pan, out_data.next_pan);
            mismatches++;
          end
          if (out_data.new_tracking_distance !== want.new_tracking_distance) begin
            $display("%0t: new_tracking_distance expected %0d actual %0d",
                     $time, want.new_tracking_distance, out_data.new_tracking_distance);
            mismatches++;
          end
          if (out_data.mean_pan !== want.mean_pan) begin
            $display("%0t: mean_pan expected %0d actual %0d",
                     $time, want.mean_pan, out_data.mean_pan);
            mismatches++;
          end
          if (out_data.target_found !== want.target_found) begin
            $display("%0t: target_found expected %0d actual %0d",
                     $time, want.target_found, out_data.target_found);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
        stall_left = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // One register write transaction; the shadow copy follows once it is taken.
  task automatic set_reg(input logic [rgpt_pkg::CFG_IDX_W-1:0] idx,
                         input logic [rgpt_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rgpt_pkg::CFG_GATE_HALF_WIDTH: gate_hw = val[rgpt_pkg::GATE_W-1:0];
      rgpt_pkg::CFG_PAN_STEP:        step_sz = val[rgpt_pkg::STEP_W-1:0];
      rgpt_pkg::CFG_STRENGTH_MIN:    str_min = val[rgpt_pkg::STR_W-1:0];
      rgpt_pkg::CFG_PAN_LOW:         pan_lo = val[rgpt_pkg::PAN_W-1:0];
      rgpt_pkg::CFG_PAN_HIGH:        pan_hi = val[rgpt_pkg::PAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input int gate, input int step, input int smin,
                         input int lo, input int hi);
    set_reg(rgpt_pkg::CFG_GATE_HALF_WIDTH, rgpt_pkg::CFG_DATA_W'(gate));
    set_reg(rgpt_pkg::CFG_PAN_STEP, rgpt_pkg::CFG_DATA_W'(step));
    set_reg(rgpt_pkg::CFG_STRENGTH_MIN, rgpt_pkg::CFG_DATA_W'(smin));
    set_reg(rgpt_pkg::CFG_PAN_LOW, rgpt_pkg::CFG_DATA_W'(lo));
    set_reg(rgpt_pkg::CFG_PAN_HIGH, rgpt_pkg::CFG_DATA_W'(hi));
  endtask

  // Every queued sample accepted, so the shadow state is current.
  task automatic settle();
    while (sample_q.size() != 0) @(posedge clk);
  endtask

  // Nothing queued or in flight; leave time for a sample that yields no decision.
  task automatic drain();
    while (sample_q.size() != 0 || in_valid || decision_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_sample(input int pan, input int dst, input int str, input bit last);
    rgpt_pkg::in_t s;
    s.sample_pan = rgpt_pkg::PAN_W'(pan);
    s.sample_distance = rgpt_pkg::DIST_W'(dst);
    s.sample_strength = rgpt_pkg::STR_W'(str);
    s.frame_end = last;
    sample_q.push_back(s);
  endtask

  // One frame built around the current tracking distance: mostly gated hits,
  // plus window edges, weak returns, pure noise and samples at the current pan.
  task automatic send_frame(input int len, input bit close);
    rgpt_pkg::in_t s;
    int lo, hi, d, mode;
    for (int i = 0; i < len; i++) begin
      mode = $urandom_range(0, 9);
      lo = int'(trk_dist) - int'(gate_hw) + 1;
      hi = int'(trk_dist) + int'(gate_hw) - 1;
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      if (hi >= lo) d = $urandom_range(hi, lo);
      else d = int'(trk_dist);
      s.sample_pan = rgpt_pkg::PAN_W'($urandom_range(0, 4095));
      s.sample_strength = rgpt_pkg::STR_W'($urandom_range(65535, str_min));
      case (mode)
        6: begin
          d = int'(trk_dist);
          if ($urandom_range(0, 1)) d = d + int'(gate_hw);
          else d = d - int'(gate_hw);
        end
        7: if (str_min != 0) s.sample_strength = rgpt_pkg::STR_W'($urandom_range(str_min - 1, 0));
        8: begin
          d = $urandom_range(0, 65535);
          s.sample_strength = rgpt_pkg::STR_W'($urandom_range(0, 65535));
        end
        9: s.sample_pan = pan_pos;
        default: ;
      endcase
      if (d > 65535) d = 65535;
      if (d < 0) d = 0;
      s.sample_distance = rgpt_pkg::DIST_W'(d);
      s.frame_end = close && (i == len - 1);
      sample_q.push_back(s);
    end
  endtask

  task automatic run_frames(input int budget);
    int sent, len;
    sent = 0;
    while (sent < budget) begin
      settle();
      if ($urandom_range(0, 7) == 0) len = $urandom_range(11, 30);
      else len = $urandom_range(1, 8);
      // some frames run at full rate on both sides
      if (calm || $urandom_range(0, 4) == 0) idle_pct = 0;
      else idle_pct = 30;
      send_frame(len, $urandom_range(0, 9) != 0);
      sent += len;
    end
  endtask

  task automatic random_config();
    set_all($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 65535));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 30;

    // Directed frames at reset settings: weak sample, both window edges,
    // pan extremes, then the decision.
    queue_sample(4095, 100, 999, 1'b0);
    queue_sample(4095, 100, 1000, 1'b0);
    queue_sample(123, 90, 65535, 1'b0);
    queue_sample(123, 110, 5000, 1'b0);
    queue_sample(0, 91, 2000, 1'b0);
    queue_sample(2000, 109, 3000, 1'b1);
    // weak sample on the frame end: dropped, decision still made, no target
    settle();
    queue_sample(777, 100, 0, 1'b1);
    // mean equal to the pan, then below it: no step either way
    settle();
    queue_sample(pan_pos, trk_dist, 4000, 1'b1);
    settle();
    queue_sample(0, trk_dist, 4000, 1'b1);

    // Wide gate around a small distance: the low bar goes negative.
    drain();
    set_reg(CFG_SPARE_IDX, 16'hFFFF);
    set_reg(rgpt_pkg::CFG_GATE_HALF_WIDTH, 16'd255);
    set_reg(rgpt_pkg::CFG_PAN_STEP, 16'd255);
    set_reg(rgpt_pkg::CFG_STRENGTH_MIN, 16'd0);
    queue_sample(4095, 0, 0, 1'b1);
    settle();
    queue_sample(1, 65535, 65535, 1'b1);

    // Crossed limits: the low limit wins.
    drain();
    set_reg(rgpt_pkg::CFG_PAN_LOW, 16'd3000);
    set_reg(rgpt_pkg::CFG_PAN_HIGH, 16'd1000);
    queue_sample(0, 65535, 1, 1'b1);

    // Climb into the upper saturation, then pin the pan at zero.
    drain();
    set_reg(rgpt_pkg::CFG_PAN_LOW, 16'd0);
    set_reg(rgpt_pkg::CFG_PAN_HIGH, 16'd4095);
    repeat (5) begin
      settle();
      queue_sample(4095, trk_dist, 1, 1'b1);
    end
    drain();
    set_reg(rgpt_pkg::CFG_PAN_HIGH, 16'd0);
    queue_sample(0, 65535, 65535, 1'b1);

    // Widest settings.
    drain();
    set_all(255, 255, 0, 0, 4095);
    run_frames(12);

    // Zero gate (nothing can pass), zero step, only full-strength samples kept.
    drain();
    set_all(0, 0, 65535, 4095, 4095);
    run_frames(12);

    // Crossed limits with random gate, step and threshold.
    drain();
    set_all($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535),
            $urandom_range(2048, 4095), $urandom_range(0, 2047));
    run_frames(12);

    // Back to the power-on values, written explicitly.
    drain();
    set_all(rgpt_pkg::RST_GATE_HALF_WIDTH, rgpt_pkg::RST_PAN_STEP,
            rgpt_pkg::RST_STRENGTH_MIN, rgpt_pkg::RST_PAN_LOW, rgpt_pkg::RST_PAN_HIGH);
    run_frames(12);

    // Point cap: a frame that fills up, after which even gated samples and
    // the frame end sample itself are dropped.
    drain();
    set_all(20, 40, 100, 0, 4095);
    queue_sample(0, 0, 0, 1'b1);
    settle();
    repeat (3) queue_sample($urandom_range(0, 4095), trk_dist, 200, 1'b0);
    repeat (rgpt_pkg::MAX_POINTS - 3)
      queue_sample($urandom_range(0, 4095), trk_dist ^ 16'h8000,
                   $urandom_range(65535, 100), 1'b0);
    queue_sample(4095, trk_dist, 65535, 1'b0);
    queue_sample(4095, trk_dist, 5, 1'b0);
    queue_sample(4095, trk_dist, 65535, 1'b1);

    // Fully random settings, raw write data above the register widths included.
    drain();
    random_config();
    run_frames(12);

    // Final stretch at full rate on both channels.
    drain();
    random_config();
    calm = 1'b1;
    run_frames(12);

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
